FILE: sv/whf_pkg.sv
// ----------------------------------------------------------------------------
// whf_pkg: worst-fit hole allocator shared definitions
// Command codes, field widths, reset values and the beat structs that pass
// between the cell chain, the output stage and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package whf_pkg;

   // default sizing of the hole table
   localparam int unsigned WHF_MAX_HOLES  = 8;
   localparam int unsigned WHF_SIZE_BITS  = 16;

   // fixed widths of the channel fields and the count register
   localparam int unsigned WHF_CMD_BITS   = 2;
   localparam int unsigned WHF_HOLE_BITS  = 3;
   localparam int unsigned WHF_FIELD_BITS = 16;
   localparam int unsigned WHF_COUNT_BITS = 4;

   localparam logic [WHF_COUNT_BITS-1:0] WHF_COUNT_RESET = 4'd8;

   // command codes; the spare code is answered as a refusal
   typedef enum logic [WHF_CMD_BITS-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_ALLOC = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // control part of the token that walks the cell chain
   typedef struct packed {
      logic                     valid;
      logic [WHF_CMD_BITS-1:0]  command;
      logic [WHF_HOLE_BITS-1:0] hole_index;
      logic                     hit;    // load or read found its entry
      logic                     found;  // allocate saw an entry in use
   } tok_ctl_type;

   // one result beat
   typedef struct packed {
      logic                      ok;
      logic [WHF_HOLE_BITS-1:0]  chosen_hole;
      logic [WHF_FIELD_BITS-1:0] remaining_size;
   } rsp_beat_type;

endpackage

`default_nettype wire

FILE: sv/whf_req_if.sv
// ----------------------------------------------------------------------------
// whf_req_if: request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface whf_req_if;
   import whf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [WHF_CMD_BITS-1:0]   command;
   logic [WHF_HOLE_BITS-1:0]  hole_index;
   logic [WHF_FIELD_BITS-1:0] size_value;

   modport source (output valid, output command, output hole_index,
                   output size_value, input ready);
   modport sink   (input valid, input command, input hole_index,
                   input size_value, output ready);
endinterface

`default_nettype wire

FILE: sv/whf_rsp_if.sv
// ----------------------------------------------------------------------------
// whf_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface whf_rsp_if;
   import whf_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      ok;
   logic [WHF_HOLE_BITS-1:0]  chosen_hole;
   logic [WHF_FIELD_BITS-1:0] remaining_size;

   modport source (output valid, output ok, output chosen_hole,
                   output remaining_size, input ready);
   modport sink   (input valid, input ok, input chosen_hole,
                   input remaining_size, output ready);
endinterface

`default_nettype wire

FILE: sv/whf_cell.sv
// ----------------------------------------------------------------------------
// whf_cell: one hole table entry
// Holds one hole size and passes the command token on to the next cell,
// applying loads, reads and the running largest-hole compare on the way.
// ----------------------------------------------------------------------------
`default_nettype none

module whf_cell import whf_pkg::*; #(
   parameter int unsigned IDX       = 0,
   parameter int unsigned IDX_W     = 3,
   parameter int unsigned SIZE_BITS = WHF_SIZE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [WHF_COUNT_BITS-1:0] hole_count,
   // token from the previous cell
   input  wire tok_ctl_type               ctl_in,
   input  wire logic [SIZE_BITS-1:0]      req_size_in,
   input  wire logic [SIZE_BITS-1:0]      best_val_in,
   input  wire logic [IDX_W-1:0]          best_idx_in,
   // token to the next cell
   output tok_ctl_type                    ctl_out,
   output logic [SIZE_BITS-1:0]           req_size_out,
   output logic [SIZE_BITS-1:0]           best_val_out,
   output logic [IDX_W-1:0]               best_idx_out,
   // allocation write-back
   input  wire logic                      wb_en,
   input  wire logic [IDX_W-1:0]          wb_idx,
   input  wire logic [SIZE_BITS-1:0]      wb_val
);

   logic [SIZE_BITS-1:0] hole_ff, hole_in;
   tok_ctl_type          ctl_ff, ctl_in_mod;
   logic [SIZE_BITS-1:0] req_size_ff;
   logic [SIZE_BITS-1:0] best_val_ff, best_val_in_mod;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in_mod;
   logic                 in_use;
   logic                 match;

   // entry in use and addressed by the token
   assign in_use = 32'(hole_count) > IDX;
   assign match  = in_use && (32'(ctl_in.hole_index) == IDX);

   // hole size update
   always_comb begin
      hole_in = hole_ff;
      if (wb_en && (wb_idx == IDX_W'(IDX))) begin
         hole_in = wb_val;
      end else if (ctl_in.valid && (ctl_in.command == CMD_LOAD) && match) begin
         hole_in = req_size_in;
      end
   end

   // token update
   always_comb begin
      ctl_in_mod      = ctl_in;
      best_val_in_mod = best_val_in;
      best_idx_in_mod = best_idx_in;
      unique case (ctl_in.command)
         CMD_LOAD: begin
            if (match) begin
               ctl_in_mod.hit  = 1'b1;
               best_val_in_mod = req_size_in;
            end
         end
         CMD_READ: begin
            if (match) begin
               ctl_in_mod.hit  = 1'b1;
               best_val_in_mod = hole_ff;
            end
         end
         CMD_ALLOC: begin
            // strict compare keeps the lowest index on ties
            if (in_use && (!ctl_in.found || (hole_ff > best_val_in))) begin
               ctl_in_mod.found = 1'b1;
               best_val_in_mod  = hole_ff;
               best_idx_in_mod  = IDX_W'(IDX);
            end
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hole_ff      <= '0;
         ctl_ff.valid <= 1'b0;
      end else begin
         hole_ff <= hole_in;
         ctl_ff  <= ctl_in_mod;
      end
   end

   // token payload
   always_ff @(posedge clock) begin
      req_size_ff <= req_size_in;
      best_val_ff <= best_val_in_mod;
      best_idx_ff <= best_idx_in_mod;
   end

   assign ctl_out      = ctl_ff;
   assign req_size_out = req_size_ff;
   assign best_val_out = best_val_ff;
   assign best_idx_out = best_idx_ff;

endmodule

`default_nettype wire

FILE: sv/whf_out_stage.sv
// ----------------------------------------------------------------------------
// whf_out_stage: result register with skid
// Holds finished result beats for the response channel; a second slot takes
// a beat that arrives while the first still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module whf_out_stage import whf_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   input  wire rsp_beat_type in_beat,
   output logic              skid_full,
   whf_rsp_if.source         rsp_bus
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   rsp_beat_type out_ff, out_in;
   rsp_beat_type skid_ff, skid_in;
   logic         take;

   assign take = out_valid_ff && rsp_bus.ready;

   // slot steering
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (in_valid) begin
         if (!out_valid_ff || take) begin
            out_in       = in_beat;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = in_beat;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign skid_full              = skid_valid_ff;
   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.ok             = out_ff.ok;
   assign rsp_bus.chosen_hole    = out_ff.chosen_hole;
   assign rsp_bus.remaining_size = out_ff.remaining_size;

endmodule

`default_nettype wire

FILE: sv/worst_fit_hole_allocator_top.sv
// The request token is registered in each hole cell in turn, then the result beat in
// the output stage. One command at a time: the token walks the chain of hole cells
// one cell per cycle and the chosen hole is written back as it leaves the chain.
// Reset: synchronous; all hole sizes clear to zero at once, hole_count to 8,
// no clearing pass.
// ----------------------------------------------------------------------------
// worst_fit_hole_allocator_top: worst-fit hole allocator
// Chain of hole cells; each command walks the chain as a token, the largest
// hole is written back on a granted allocate.
// ----------------------------------------------------------------------------
`default_nettype none

module worst_fit_hole_allocator_top import whf_pkg::*; #(
   parameter int unsigned MAX_HOLES = WHF_MAX_HOLES,
   parameter int unsigned SIZE_BITS = WHF_SIZE_BITS
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_wr_en,
   input  wire logic [WHF_COUNT_BITS-1:0] csr_wr_data,
   whf_req_if.sink                        req_bus,
   whf_rsp_if.source                      rsp_bus
);

   localparam int unsigned IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;

   logic [WHF_COUNT_BITS-1:0] hole_count_ff;
   logic                      busy_ff, busy_in;
   logic                      req_fire;
   logic                      skid_full;

   tok_ctl_type          ctl_chain      [MAX_HOLES+1];
   logic [SIZE_BITS-1:0] req_size_chain [MAX_HOLES+1];
   logic [SIZE_BITS-1:0] best_val_chain [MAX_HOLES+1];
   logic [IDX_W-1:0]     best_idx_chain [MAX_HOLES+1];
   logic [MAX_HOLES-1:0] tok_valid_vec;

   tok_ctl_type          exit_ctl;
   logic [SIZE_BITS-1:0] exit_size;
   logic [SIZE_BITS-1:0] exit_best;
   logic [IDX_W-1:0]     exit_idx;
   logic                 grant;
   logic                 wb_en;
   logic [SIZE_BITS-1:0] wb_val;
   rsp_beat_type         result;

   // count register
   always_ff @(posedge clock) begin
      if (reset) begin
         hole_count_ff <= WHF_COUNT_RESET;
      end else if (csr_wr_en) begin
         hole_count_ff <= csr_wr_data;
      end
   end

   // one command in the chain at a time
   assign req_bus.ready = !busy_ff && !skid_full;
   assign req_fire      = req_bus.valid && req_bus.ready;

   always_comb begin
      busy_in = busy_ff;
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (exit_ctl.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // token injected at the head of the chain
   always_comb begin
      ctl_chain[0].valid      = req_fire;
      ctl_chain[0].command    = req_bus.command;
      ctl_chain[0].hole_index = req_bus.hole_index;
      ctl_chain[0].hit        = 1'b0;
      ctl_chain[0].found      = 1'b0;
   end
   assign req_size_chain[0] = SIZE_BITS'(req_bus.size_value);
   assign best_val_chain[0] = '0;
   assign best_idx_chain[0] = '0;

   // chain of hole cells
   for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
      whf_cell #(
         .IDX       (i),
         .IDX_W     (IDX_W),
         .SIZE_BITS (SIZE_BITS)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .hole_count   (hole_count_ff),
         .ctl_in       (ctl_chain[i]),
         .req_size_in  (req_size_chain[i]),
         .best_val_in  (best_val_chain[i]),
         .best_idx_in  (best_idx_chain[i]),
         .ctl_out      (ctl_chain[i+1]),
         .req_size_out (req_size_chain[i+1]),
         .best_val_out (best_val_chain[i+1]),
         .best_idx_out (best_idx_chain[i+1]),
         .wb_en        (wb_en),
         .wb_idx       (exit_idx),
         .wb_val       (wb_val)
      );
      assign tok_valid_vec[i] = ctl_chain[i+1].valid;
   end

   assign exit_ctl  = ctl_chain[MAX_HOLES];
   assign exit_size = req_size_chain[MAX_HOLES];
   assign exit_best = best_val_chain[MAX_HOLES];
   assign exit_idx  = best_idx_chain[MAX_HOLES];

   // grant decision and write-back of the chosen hole
   assign grant  = exit_ctl.found && (exit_best >= exit_size);
   assign wb_val = exit_best - exit_size;
   assign wb_en  = exit_ctl.valid && (exit_ctl.command == CMD_ALLOC) && grant;

   // result beat
   always_comb begin
      result = '0;
      unique case (exit_ctl.command)
         CMD_LOAD, CMD_READ: begin
            result.ok          = exit_ctl.hit;
            result.chosen_hole = exit_ctl.hole_index;
            if (exit_ctl.hit) begin
               result.remaining_size = WHF_FIELD_BITS'(exit_best);
            end
         end
         CMD_ALLOC: begin
            if (grant) begin
               result.ok             = 1'b1;
               result.chosen_hole    = WHF_HOLE_BITS'(exit_idx);
               result.remaining_size = WHF_FIELD_BITS'(wb_val);
            end
         end
         default: begin
         end
      endcase
   end

   whf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (exit_ctl.valid),
      .in_beat   (result),
      .skid_full (skid_full),
      .rsp_bus   (rsp_bus)
   );

   // at most one token in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one token in the cell chain");

   // a token only leaves while a command is outstanding
   a_exit_busy: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid |-> busy_ff)
      else $error("token left the chain with no command outstanding");

   // the skid slot is free whenever a result arrives
   a_skid_free: assert property (@(posedge clock) disable iff (reset)
      exit_ctl.valid |-> !skid_full)
      else $error("result arrived with the skid slot full");

   // an accepted beat keeps the block busy on the next cycle
   a_fire_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff)
      else $error("block not busy after accepting a beat");

endmodule

`default_nettype wire

FILE: bench/tb_worst_fit_hole_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_worst_fit_hole_allocator_top: self-checking bench for the hole allocator
// Drives load, allocate, read and spare commands through the request channel
// under several hole_count settings. A local copy of the hole table predicts
// each result beat, and every beat on the result channel is compared with the
// oldest prediction. Both channels idle at random, and the result side is
// held off once for a long stretch so the block backs up its request side.
// ----------------------------------------------------------------------------

module tb_worst_fit_hole_allocator_top;
   import whf_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned DRAIN_CYCLES = 2 * (WHF_MAX_HOLES + 1);
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned MAX_REPORTS  = 10;

   // spare command code, answered as a refusal
   localparam logic [WHF_CMD_BITS-1:0] CMD_SPARE = 2'd3;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      csr_wr_en;
   logic [WHF_COUNT_BITS-1:0] csr_wr_data;

   whf_req_if req_bus ();
   whf_rsp_if rsp_bus ();

   worst_fit_hole_allocator_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // local copy of the hole table and the count register
   logic [WHF_SIZE_BITS-1:0]  hole_model [WHF_MAX_HOLES];
   logic [WHF_COUNT_BITS-1:0] count_model;

   rsp_beat_type answers_due [$];
   int unsigned  mismatches   = 0;
   int unsigned  cycle_count  = 0;
   bit           req_idle_on  = 1'b1;
   bit           rsp_idle_on  = 1'b1;
   bit           rsp_hold     = 1'b0;
   int unsigned  rsp_gap;

   // clock, period 8
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // entries in use, count clamped to the table size
   function automatic int unsigned holes_in_use();
      return (count_model > WHF_MAX_HOLES) ? WHF_MAX_HOLES : 32'(count_model);
   endfunction

   // largest hole among the entries in use, lowest index on ties
   function automatic int unsigned largest_entry();
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < holes_in_use(); i++)
         if (hole_model[i] > hole_model[best]) best = i;
      return best;
   endfunction

   // apply one command to the local table and return the beat it answers
   function automatic rsp_beat_type run_hole_command(
      input logic [WHF_CMD_BITS-1:0]   cmd,
      input logic [WHF_HOLE_BITS-1:0]  idx,
      input logic [WHF_FIELD_BITS-1:0] size
   );
      rsp_beat_type ans;
      int unsigned  used;
      int unsigned  best;
      ans  = '0;
      used = holes_in_use();
      unique case (cmd)
         CMD_LOAD: begin
            ans.chosen_hole = idx;
            if (idx < used) begin
               hole_model[idx]    = size;
               ans.ok             = 1'b1;
               ans.remaining_size = size;
            end
         end
         CMD_ALLOC: begin
            if (used != 0) begin
               best = largest_entry();
               if (hole_model[best] >= size) begin
                  hole_model[best]   = hole_model[best] - size;
                  ans.ok             = 1'b1;
                  ans.chosen_hole    = WHF_HOLE_BITS'(best);
                  ans.remaining_size = hole_model[best];
               end
            end
         end
         CMD_READ: begin
            ans.chosen_hole = idx;
            if (idx < used) begin
               ans.ok             = 1'b1;
               ans.remaining_size = hole_model[idx];
            end
         end
         default: ;
      endcase
      return ans;
   endfunction

   // result side ready: random gaps per beat, plus the long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_gap = 0;
      end else if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_gap = rsp_idle_on ? $urandom_range(0, 19) : 0;
         if (rsp_gap != 0 || rsp_hold) rsp_bus.ready <= 1'b0;
      end else if (rsp_hold) begin
         rsp_bus.ready <= 1'b0;
      end else if (!rsp_bus.ready) begin
         if (rsp_gap != 0) rsp_gap--;
         else rsp_bus.ready <= 1'b1;
      end
   end

   // compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_beat_type got;
      rsp_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.ok             = rsp_bus.ok;
         got.chosen_hole    = rsp_bus.chosen_hole;
         got.remaining_size = rsp_bus.remaining_size;
         if (answers_due.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("rsp beat with nothing expected: ok=%0d hole=%0d rem=%0d",
                        got.ok, got.chosen_hole, got.remaining_size);
         end else begin
            want = answers_due.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("rsp mismatch: want ok=%0d hole=%0d rem=%0d, got %0d %0d %0d",
                           want.ok, want.chosen_hole, want.remaining_size,
                           got.ok, got.chosen_hole, got.remaining_size);
            end
         end
      end
   end

   // offer one command beat, predict its answer once accepted
   task automatic send_command(
      input logic [WHF_CMD_BITS-1:0]   cmd,
      input logic [WHF_HOLE_BITS-1:0]  idx,
      input logic [WHF_FIELD_BITS-1:0] size
   );
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 19) : 0;
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.hole_index <= idx;
      req_bus.size_value <= size;
      do @(posedge clock); while (!req_bus.ready);
      answers_due.push_back(run_hole_command(cmd, idx, size));
   endtask

   // stop offering and wait for every predicted beat to come back
   task automatic drain_answers();
      req_bus.valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write hole_count while the block is idle
   task automatic set_hole_count(input logic [WHF_COUNT_BITS-1:0] value);
      drain_answers();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      count_model = value;
   endtask

   // mostly well-formed traffic: loads in range, allocates that often fit
   task automatic send_random_command();
      int unsigned              pick;
      int unsigned              used;
      int unsigned              top;
      logic [WHF_CMD_BITS-1:0]   cmd;
      logic [WHF_HOLE_BITS-1:0]  idx;
      logic [WHF_FIELD_BITS-1:0] size;
      used = holes_in_use();
      pick = $urandom_range(0, 99);
      if (used != 0 && $urandom_range(0, 9) != 0) idx = 3'($urandom_range(0, used - 1));
      else idx = 3'($urandom_range(0, 7));
      size = 16'($urandom_range(0, 16'hFFFF));
      if (pick < 35) begin
         cmd = CMD_LOAD;
         if ($urandom_range(0, 9) == 0) size = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end else if (pick < 75) begin
         cmd = CMD_ALLOC;
         top = (used != 0) ? 32'(hole_model[largest_entry()]) : 0;
         pick = $urandom_range(0, 19);
         if (pick < 12) size = 16'($urandom_range(0, top));
         else if (pick < 15) size = '0;
         else if (pick < 17) size = 16'(top);
      end else if (pick < 92) begin
         cmd = CMD_READ;
      end else begin
         // noise: spare code or a load anywhere in the index range
         cmd = $urandom_range(0, 1) ? CMD_SPARE : CMD_LOAD;
         idx = 3'($urandom_range(0, 7));
      end
      send_command(cmd, idx, size);
   endtask

   task automatic send_random_burst(input int unsigned beats);
      repeat (beats) send_random_command();
   endtask

   // table straight out of reset: all holes zero, count 8
   task automatic test_reset_state();
      send_command(CMD_READ, 3'd0, 16'h0000);
      send_command(CMD_ALLOC, 3'd5, 16'h0000);
      send_command(CMD_ALLOC, 3'd0, 16'h0001);
      send_command(CMD_READ, 3'd7, 16'hFFFF);
   endtask

   // loads at the size extremes, ties, grants, refusals, spare code
   task automatic test_load_and_allocate();
      send_command(CMD_LOAD, 3'd7, 16'hFFFF);
      send_command(CMD_LOAD, 3'd0, 16'h0000);
      send_command(CMD_LOAD, 3'd3, 16'hFFFF);
      send_command(CMD_LOAD, 3'd5, 16'd1234);
      send_command(CMD_ALLOC, 3'd0, 16'hFFFF);
      send_command(CMD_ALLOC, 3'd0, 16'h0001);
      send_command(CMD_READ, 3'd7, 16'h0000);
      send_command(CMD_ALLOC, 3'd0, 16'h0000);
      send_command(CMD_ALLOC, 3'd0, 16'hFFFF);
      send_command(CMD_SPARE, 3'd5, 16'hFFFF);
      send_command(CMD_READ, 3'd3, 16'hAAAA);
   endtask

   // index range edges at small, zero and oversized counts
   task automatic test_count_limits();
      set_hole_count(4'd2);
      send_command(CMD_LOAD, 3'd2, 16'h5555);
      send_command(CMD_READ, 3'd7, 16'h0000);
      send_command(CMD_ALLOC, 3'd0, 16'h0001);
      set_hole_count(4'd0);
      send_command(CMD_ALLOC, 3'd0, 16'h0000);
      send_command(CMD_LOAD, 3'd0, 16'h1111);
      send_command(CMD_READ, 3'd0, 16'h0000);
      set_hole_count(4'd15);
      send_command(CMD_LOAD, 3'd7, 16'h8000);
      send_command(CMD_READ, 3'd7, 16'h0000);
   endtask

   // random traffic under one count setting
   task automatic test_random_count(input logic [WHF_COUNT_BITS-1:0] value,
                                    input int unsigned beats);
      set_hole_count(value);
      send_random_burst(beats);
   endtask

   // result side held off while requests keep coming
   task automatic test_output_stall();
      drain_answers();
      req_idle_on = 1'b0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
      join_none
      send_random_burst(40);
      drain_answers();
      req_idle_on = 1'b1;
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      send_random_burst(60);
      drain_answers();
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
   endtask

   // bursts with the sender pausing until everything has come back
   task automatic test_pause_between_bursts();
      repeat (3) begin
         send_random_burst(20);
         drain_answers();
      end
   endtask

   initial begin
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_wr_data        <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.command    <= CMD_LOAD;
      req_bus.hole_index <= '0;
      req_bus.size_value <= '0;
      foreach (hole_model[i]) hole_model[i] = '0;
      count_model = WHF_COUNT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_load_and_allocate();
      test_count_limits();
      test_random_count(4'd8, 200);
      test_output_stall();
      test_back_to_back();
      test_pause_between_bursts();
      test_random_count(4'd3, 100);
      test_random_count(4'd1, 60);
      test_random_count(4'd0, 30);
      test_random_count(4'd15, 100);
      test_random_count(4'd5, 60);
      drain_answers();

      if (mismatches == 0 && answers_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
